// ===== design/hcs_pkg.sv =====
package hcs_pkg;

  // graph size and derived widths
  localparam int MaxVertices = 32;
  localparam int VtxW        = $clog2(MaxVertices);
  localparam int CntW        = $clog2(MaxVertices + 1);
  localparam int CmdW        = 2;

  // command codes carried on the input word
  localparam logic [CmdW-1:0] CmdAddEdge = 2'd0;
  localparam logic [CmdW-1:0] CmdSearch  = 2'd1;
  localparam logic [CmdW-1:0] CmdClear   = 2'd2;

  // datapath operations
  typedef enum logic [2:0] {
    DpNop,
    DpEdge,
    DpClear,
    DpInit,
    DpPush,
    DpPop
  } dp_op_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e            op;
    logic              emit;
    logic [CntW-1:0]   rd_idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              empty;
    logic              full;
    logic              close_ok;
    logic              has_next;
    logic              emit_last;
    logic [VtxW-1:0]   rd_vertex;
  } dp_stat_t;

endpackage

// ===== design/hcs_datapath.sv =====
module hcs_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hcs_pkg::dp_cmd_t             cmd_i,
  input  logic [hcs_pkg::VtxW-1:0]     edge_from_i,
  input  logic [hcs_pkg::VtxW-1:0]     edge_to_i,
  input  logic                         cfg_we_i,
  input  logic [hcs_pkg::CntW-1:0]     cfg_data_i,
  output hcs_pkg::dp_stat_t            stat_o
);

  localparam int NV = hcs_pkg::MaxVertices;
  localparam int VW = hcs_pkg::VtxW;
  localparam int CW = hcs_pkg::CntW;

  logic [NV-1:0] adj_q [NV];
  logic [NV-1:0] visited_q, visited_d;
  logic [CW-1:0] depth_q, depth_d;
  logic [CW-1:0] cur_q, cur_d;
  logic [CW-1:0] n_q, n_d;
  logic [VW-1:0] stack_q [NV];

  logic [VW-1:0] top_idx;
  logic [VW-1:0] rd_addr;
  logic [VW-1:0] rd_vertex;
  logic [NV-1:0] row;
  logic [NV-1:0] cand;
  logic [VW-1:0] next_u;
  logic          edge_ok;

  // clamp the vertex count into the supported range
  always_comb begin
    n_d = n_q;
    if (cfg_we_i) begin
      if (cfg_data_i < CW'(2)) begin
        n_d = CW'(2);
      end else if (cfg_data_i > CW'(NV)) begin
        n_d = CW'(NV);
      end else begin
        n_d = cfg_data_i;
      end
    end
  end

  // one read port on the path stack: top of stack while searching, cursor while emitting
  assign top_idx   = VW'(depth_q - CW'(1));
  assign rd_addr   = cmd_i.emit ? cmd_i.rd_idx[VW-1:0] : top_idx;
  assign rd_vertex = stack_q[rd_addr];
  assign row       = adj_q[rd_vertex];

  // unvisited neighbours at or after the cursor and below the vertex count
  always_comb begin
    for (int i = 0; i < NV; i++) begin
      cand[i] = row[i] && !visited_q[i] && (CW'(i) >= cur_q) && (CW'(i) < n_q);
    end
  end

  // lowest candidate wins
  always_comb begin
    next_u = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (cand[i]) begin
        next_u = VW'(i);
      end
    end
  end

  assign edge_ok = ({1'b0, edge_from_i} < n_q) && ({1'b0, edge_to_i} < n_q);

  // status back to the controller
  assign stat_o.empty     = (depth_q == '0);
  assign stat_o.full      = (depth_q == n_q);
  assign stat_o.close_ok  = row[0];
  assign stat_o.has_next  = |cand;
  assign stat_o.emit_last = (cmd_i.rd_idx == n_q);
  assign stat_o.rd_vertex = rd_vertex;

  // walk state: visited set, depth and neighbour cursor
  always_comb begin
    visited_d = visited_q;
    depth_d   = depth_q;
    cur_d     = cur_q;
    case (cmd_i.op)
      hcs_pkg::DpInit: begin
        visited_d = NV'(1);
        depth_d   = CW'(1);
        cur_d     = '0;
      end
      hcs_pkg::DpPush: begin
        visited_d = visited_q | (NV'(1) << next_u);
        depth_d   = depth_q + CW'(1);
        cur_d     = '0;
      end
      hcs_pkg::DpPop: begin
        // resume the parent's scan just past the vertex being dropped
        visited_d = visited_q & ~(NV'(1) << rd_vertex);
        depth_d   = depth_q - CW'(1);
        cur_d     = {1'b0, rd_vertex} + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      depth_q   <= '0;
      cur_q     <= '0;
      n_q       <= CW'(2);
    end else begin
      visited_q <= visited_d;
      depth_q   <= depth_d;
      cur_q     <= cur_d;
      n_q       <= n_d;
    end
  end

  // adjacency matrix: set both mirror bits, or clear everything
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        adj_q[i] <= '0;
      end
    end else if (cmd_i.op == hcs_pkg::DpClear) begin
      for (int i = 0; i < NV; i++) begin
        adj_q[i] <= '0;
      end
    end else if (cmd_i.op == hcs_pkg::DpEdge && edge_ok) begin
      adj_q[edge_from_i][edge_to_i] <= 1'b1;
      adj_q[edge_to_i][edge_from_i] <= 1'b1;
    end
  end

  // path stack: root on init, new vertex on push
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == hcs_pkg::DpInit) begin
      stack_q[0] <= '0;
    end else if (cmd_i.op == hcs_pkg::DpPush) begin
      stack_q[depth_q[VW-1:0]] <= next_u;
    end
  end

endmodule

// ===== design/hcs_ctrl.sv =====
module hcs_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic [hcs_pkg::CmdW-1:0]   command_i,
  input  hcs_pkg::dp_stat_t          stat_i,
  output hcs_pkg::dp_cmd_t           cmd_o,
  output logic                       busy,
  output logic                       res_strobe_o,
  output logic                       found_o,
  output logic [hcs_pkg::VtxW-1:0]   vertex_o,
  output logic                       last_o
);

  localparam int VW = hcs_pkg::VtxW;
  localparam int CW = hcs_pkg::CntW;

  typedef enum logic [1:0] {
    StIdle,
    StSearch,
    StEmit
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] k_q, k_d;
  logic          strobe_q, strobe_d;
  logic          found_q, found_d;
  logic [VW-1:0] vertex_q, vertex_d;
  logic          last_q, last_d;

  // sequence commands and the result words
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    strobe_d   = 1'b0;
    found_d    = found_q;
    vertex_d   = vertex_q;
    last_d     = last_q;
    cmd_o.op     = hcs_pkg::DpNop;
    cmd_o.emit   = 1'b0;
    cmd_o.rd_idx = k_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          case (command_i)
            hcs_pkg::CmdAddEdge: cmd_o.op = hcs_pkg::DpEdge;
            hcs_pkg::CmdClear:   cmd_o.op = hcs_pkg::DpClear;
            hcs_pkg::CmdSearch: begin
              cmd_o.op = hcs_pkg::DpInit;
              state_d  = StSearch;
            end
            default: begin
            end
          endcase
        end
      end
      StSearch: begin
        if (stat_i.empty) begin
          // walk exhausted: one not-found word
          strobe_d = 1'b1;
          found_d  = 1'b0;
          vertex_d = '0;
          last_d   = 1'b1;
          state_d  = StIdle;
        end else if (stat_i.full) begin
          if (stat_i.close_ok) begin
            k_d     = '0;
            state_d = StEmit;
          end else begin
            cmd_o.op = hcs_pkg::DpPop;
          end
        end else if (stat_i.has_next) begin
          cmd_o.op = hcs_pkg::DpPush;
        end else begin
          cmd_o.op = hcs_pkg::DpPop;
        end
      end
      StEmit: begin
        // stream the stack bottom up, then close on vertex 0
        cmd_o.emit = 1'b1;
        strobe_d   = 1'b1;
        found_d    = 1'b1;
        last_d     = stat_i.emit_last;
        vertex_d   = stat_i.emit_last ? '0 : stat_i.rd_vertex;
        k_d        = k_q + CW'(1);
        if (stat_i.emit_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      k_q      <= '0;
      strobe_q <= 1'b0;
      found_q  <= 1'b0;
      vertex_q <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      strobe_q <= strobe_d;
      found_q  <= found_d;
      vertex_q <= vertex_d;
      last_q   <= last_d;
    end
  end

  assign busy         = (state_q != StIdle);
  assign res_strobe_o = strobe_q;
  assign found_o      = found_q;
  assign vertex_o     = vertex_q;
  assign last_o       = last_q;

endmodule

// ===== design/hamiltonian_cycle_search.sv =====
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+----------------------------------
// command  | in        | start high, busy low    | command_i, edge_from_i, edge_to_i
// config   | in        | cfg_valid_i, cfg_ready_o| cfg_data_i (vertex_count)
// result   | out       | res_strobe_o, one cycle | found_o, vertex_o, last_o
//
// Add edge and clear finish in the accepting cycle; busy stays low.
// A search loads the root in its accepting cycle, then pushes or pops the path stack one
// step at a time (single stack read port and adjacency row lookup), checks the closing
// edge at full depth, then emits n+1 words, or a single not-found word.
// Reset is asynchronous, active low, and clears the adjacency matrix at once.
// Results are registered and cannot be stalled by the receiver.
module hamiltonian_cycle_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [hcs_pkg::CmdW-1:0]   command_i,
  input  logic [hcs_pkg::VtxW-1:0]   edge_from_i,
  input  logic [hcs_pkg::VtxW-1:0]   edge_to_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [hcs_pkg::CntW-1:0]   cfg_data_i,
  output logic                       res_strobe_o,
  output logic                       found_o,
  output logic [hcs_pkg::VtxW-1:0]   vertex_o,
  output logic                       last_o
);

  hcs_pkg::dp_cmd_t  dp_cmd;
  hcs_pkg::dp_stat_t dp_stat;

  // the user must write the register only while idle (the block does not enforce it), so always take it
  assign cfg_ready_o = 1'b1;

  hcs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .command_i    (command_i),
    .stat_i       (dp_stat),
    .cmd_o        (dp_cmd),
    .busy         (busy),
    .res_strobe_o (res_strobe_o),
    .found_o      (found_o),
    .vertex_o     (vertex_o),
    .last_o       (last_o)
  );

  hcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .edge_from_i (edge_from_i),
    .edge_to_i   (edge_to_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (dp_stat)
  );

  // a result word only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(busy))
    else $error("result word without a running search");

  // a not-found word is always the lone closing word on vertex 0
  a_miss_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !found_o) |-> (last_o && vertex_o == '0))
    else $error("malformed not-found word");

  // the closing word releases the block
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && last_o) |-> !busy)
    else $error("still busy after the closing word");

endmodule

// ===== test/hamiltonian_cycle_search_checker.sv =====
module hamiltonian_cycle_search_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic [hcs_pkg::CmdW-1:0] command_i,
  input  logic [hcs_pkg::VtxW-1:0] edge_from_i,
  input  logic [hcs_pkg::VtxW-1:0] edge_to_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [hcs_pkg::CntW-1:0] cfg_data_i,
  input  logic                     res_strobe_i,
  input  logic                     found_i,
  input  logic [hcs_pkg::VtxW-1:0] vertex_i,
  input  logic                     last_i,
  output int unsigned              error_count_o,
  output int unsigned              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW = hcs_pkg::VtxW;
  localparam int CW = hcs_pkg::CntW;

  typedef struct packed {
    logic                     found;
    logic [hcs_pkg::VtxW-1:0] vertex;
    logic                     last;
  } cycle_word_t;

  // predicted result words, oldest first
  cycle_word_t cycle_words_q[$];

  // shadow of the graph and the vertex count register
  logic [hcs_pkg::MaxVertices-1:0] adj_rows [hcs_pkg::MaxVertices];
  logic [hcs_pkg::CntW-1:0]        vertex_count_reg;

  // clamp the register to the range the search honors
  function automatic int live_vertices();
    if (vertex_count_reg < 2) return 2;
    if (vertex_count_reg > hcs_pkg::MaxVertices) return hcs_pkg::MaxVertices;
    return int'(vertex_count_reg);
  endfunction

  // append one predicted word at the tail
  function automatic void queue_word(input logic          found,
                                     input logic [VW-1:0] vertex,
                                     input logic          last);
    cycle_word_t w;
    w.found  = found;
    w.vertex = vertex;
    w.last   = last;
    cycle_words_q.insert(cycle_words_q.size(), w);
  endfunction

  // walk the graph depth first from vertex 0 and queue the cycle words it yields
  function automatic void trace_cycle(input int n);
    logic [hcs_pkg::VtxW-1:0]        trail [hcs_pkg::MaxVertices];
    logic [hcs_pkg::CntW-1:0]        cursor [hcs_pkg::MaxVertices];
    logic [hcs_pkg::MaxVertices-1:0] seen;
    int depth;
    int top;
    int v;
    int u;
    int k;
    bit hit;
    bit moved;
    trail[0]  = '0;
    cursor[0] = '0;
    seen      = '0;
    seen[0]   = 1'b1;
    depth     = 1;
    hit       = 1'b0;
    while (depth > 0) begin
      top   = depth - 1;
      v     = int'(trail[top]);
      moved = 1'b0;
      if (depth == n) begin
        if (adj_rows[v][0]) begin
          hit = 1'b1;
          break;
        end
      end else begin
        for (u = int'(cursor[top]); u < n; u++) begin
          if (adj_rows[v][u] && !seen[u]) begin
            cursor[top]  = CW'(u + 1);
            trail[depth] = VW'(u);
            cursor[depth] = '0;
            seen[u]      = 1'b1;
            depth++;
            moved = 1'b1;
            break;
          end
        end
      end
      // backtrack when no unvisited neighbor is left
      if (!moved) begin
        seen[v] = 1'b0;
        depth--;
      end
    end
    if (hit) begin
      for (k = 0; k < n; k++) queue_word(1'b1, trail[k], 1'b0);
      queue_word(1'b1, '0, 1'b1);
    end else begin
      queue_word(1'b0, '0, 1'b1);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cycle_word_t want;
    int r;
    int n;
    if (!rst_ni) begin
      for (r = 0; r < hcs_pkg::MaxVertices; r++) adj_rows[r] = '0;
      vertex_count_reg = CW'(2);
      cycle_words_q.delete();
    end else begin
      // compare a result word with the oldest prediction
      if (res_strobe_i) begin
        if (cycle_words_q.size() == 0) begin
          $error("unexpected result word: found %0d vertex %0d last %0d",
                 found_i, vertex_i, last_i);
          error_count_o++;
        end else begin
          want = cycle_words_q.pop_front();
          if (found_i !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found_i);
            error_count_o++;
          end
          if (vertex_i !== want.vertex) begin
            $error("vertex: expected %0d, actual %0d", want.vertex, vertex_i);
            error_count_o++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last_i);
            error_count_o++;
          end
        end
      end
      // track register writes
      if (cfg_valid_i && cfg_ready_i) vertex_count_reg = cfg_data_i;
      // apply an accepted command word
      if (start_i && !busy_i) begin
        n = live_vertices();
        case (command_i)
          hcs_pkg::CmdAddEdge: begin
            if (edge_from_i < n && edge_to_i < n) begin
              adj_rows[edge_from_i][edge_to_i] = 1'b1;
              adj_rows[edge_to_i][edge_from_i] = 1'b1;
            end
          end
          hcs_pkg::CmdClear: begin
            for (r = 0; r < hcs_pkg::MaxVertices; r++) adj_rows[r] = '0;
          end
          hcs_pkg::CmdSearch: trace_cycle(n);
          default: ;
        endcase
      end
    end
    pending_o = cycle_words_q.size();
  end

endmodule

// ===== test/hamiltonian_cycle_search_test.sv =====
module hamiltonian_cycle_search_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [hcs_pkg::CmdW-1:0] CmdUnused = 2'd3;
  localparam int CycleLimit  = 400000;
  localparam int RandomWords = 220;

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     start      = 1'b0;
  logic [hcs_pkg::CmdW-1:0] command    = '0;
  logic [hcs_pkg::VtxW-1:0] edge_from  = '0;
  logic [hcs_pkg::VtxW-1:0] edge_to    = '0;
  logic                     cfg_valid  = 1'b0;
  logic [hcs_pkg::CntW-1:0] cfg_data   = '0;
  logic                     busy;
  logic                     cfg_ready;
  logic                     res_strobe;
  logic                     found;
  logic [hcs_pkg::VtxW-1:0] vertex;
  logic                     last;
  int unsigned              fail_count;
  int unsigned              pending;

  // sender idle percentage and the vertex count now in force
  int idle_pct = 12;
  int live_n   = 2;
  int useful   = 0;

  hamiltonian_cycle_search u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .command_i    (command),
    .edge_from_i  (edge_from),
    .edge_to_i    (edge_to),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .res_strobe_o (res_strobe),
    .found_o      (found),
    .vertex_o     (vertex),
    .last_o       (last)
  );

  hamiltonian_cycle_search_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .command_i     (command),
    .edge_from_i   (edge_from),
    .edge_to_i     (edge_to),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .res_strobe_i  (res_strobe),
    .found_i       (found),
    .vertex_i      (vertex),
    .last_i        (last),
    .error_count_o (fail_count),
    .pending_o     (pending)
  );

  always #5 clk = ~clk;

  // hand one command word over; entered and left at a falling edge
  task automatic send_word(input logic [hcs_pkg::CmdW-1:0] cmd,
                           input int                       a,
                           input int                       b);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    command   <= cmd;
    edge_from <= a[hcs_pkg::VtxW-1:0];
    edge_to   <= b[hcs_pkg::VtxW-1:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender until every predicted word has come out
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // write the vertex count while the block is idle
  task automatic write_count(input int raw);
    drain();
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= raw[hcs_pkg::CntW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    live_n = (raw < 2) ? 2 : (raw > hcs_pkg::MaxVertices) ? hcs_pkg::MaxVertices : raw;
  endtask

  // stop a hung run
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("hamiltonian_cycle_search_test: errors");
    $finish;
  end

  initial begin
    int v;
    int k;
    int a;
    int b;
    int raw;
    bit closed;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // two vertices at the reset count: empty graph, single edge, ignored words
    send_word(hcs_pkg::CmdSearch, 0, 0);
    send_word(hcs_pkg::CmdAddEdge, 0, 1);
    send_word(hcs_pkg::CmdAddEdge, 0, 5);
    send_word(hcs_pkg::CmdAddEdge, 1, 1);
    send_word(CmdUnused, 31, 31);
    send_word(hcs_pkg::CmdSearch, 31, 31);
    send_word(hcs_pkg::CmdClear, 0, 0);
    send_word(hcs_pkg::CmdSearch, 0, 0);

    // count below range acts as two
    write_count(0);
    send_word(hcs_pkg::CmdAddEdge, 1, 0);
    send_word(hcs_pkg::CmdSearch, 0, 0);

    // count above range acts as the maximum
    write_count(63);
    send_word(hcs_pkg::CmdAddEdge, 31, 0);
    send_word(hcs_pkg::CmdAddEdge, 31, 31);
    send_word(hcs_pkg::CmdSearch, 0, 0);

    // triangle, then an edge outside it
    write_count(3);
    send_word(hcs_pkg::CmdClear, 31, 31);
    send_word(hcs_pkg::CmdAddEdge, 0, 1);
    send_word(hcs_pkg::CmdAddEdge, 1, 2);
    send_word(hcs_pkg::CmdAddEdge, 2, 0);
    send_word(hcs_pkg::CmdAddEdge, 2, 7);
    send_word(hcs_pkg::CmdSearch, 0, 0);
    write_count(1);
    send_word(hcs_pkg::CmdSearch, 0, 0);

    // random rounds: mostly small graphs, sometimes a wide ascending ring
    while (useful < RandomWords) begin
      idle_pct = (useful < RandomWords / 3) ? 12 : (useful < 2 * RandomWords / 3) ? 88 : 0;
      if ($urandom_range(0, 9) < 2) begin
        case ($urandom_range(0, 2))
          0:       raw = 32;
          1:       raw = 63;
          default: raw = $urandom_range(7, 63);
        endcase
        write_count(raw);
        send_word(hcs_pkg::CmdClear, $urandom_range(0, 31), $urandom_range(0, 31));
        useful++;
        closed = ($urandom_range(0, 3) != 0);
        // load the ring in ascending order so the walk never backtracks deeply
        for (v = 0; v < live_n - 1; v++) begin
          if ($urandom_range(0, 1)) send_word(hcs_pkg::CmdAddEdge, v, v + 1);
          else send_word(hcs_pkg::CmdAddEdge, v + 1, v);
          useful++;
        end
        if (closed) begin
          send_word(hcs_pkg::CmdAddEdge, live_n - 1, 0);
          useful++;
          // chords cannot divert an ascending walk once the ring closes
          repeat ($urandom_range(0, 6)) begin
            send_word(hcs_pkg::CmdAddEdge, $urandom_range(0, live_n - 1),
                      $urandom_range(0, live_n - 1));
            useful++;
          end
        end
        send_word(hcs_pkg::CmdSearch, $urandom_range(0, 31), $urandom_range(0, 31));
        useful++;
      end else begin
        if (live_n > 6 || $urandom_range(0, 2) == 0) write_count($urandom_range(0, 6));
        if ($urandom_range(0, 2) == 0) begin
          send_word(hcs_pkg::CmdClear, $urandom_range(0, 31), $urandom_range(0, 31));
          useful++;
        end
        k = $urandom_range(0, 2 * live_n + 2);
        repeat (k) begin
          if ($urandom_range(0, 7) == 0) begin
            // noise: unused code or endpoints anywhere in the field
            a = $urandom_range(0, 31);
            b = $urandom_range(0, 31);
            if ($urandom_range(0, 1)) send_word(CmdUnused, a, b);
            else begin
              send_word(hcs_pkg::CmdAddEdge, a, b);
              if (a < live_n && b < live_n) useful++;
            end
          end else begin
            send_word(hcs_pkg::CmdAddEdge, $urandom_range(0, live_n - 1),
                      $urandom_range(0, live_n - 1));
            useful++;
          end
        end
        send_word(hcs_pkg::CmdSearch, $urandom_range(0, 31), $urandom_range(0, 31));
        useful++;
        if ($urandom_range(0, 5) == 0) begin
          send_word(hcs_pkg::CmdSearch, $urandom_range(0, 31), $urandom_range(0, 31));
          useful++;
        end
        if ($urandom_range(0, 5) == 0) drain();
      end
    end

    // let the last results out, then give the verdict
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("hamiltonian_cycle_search_test: clean");
    end else begin
      $display("hamiltonian_cycle_search_test: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hcs_pkg.sv
design/hcs_datapath.sv
design/hcs_ctrl.sv
design/hamiltonian_cycle_search.sv
test/hamiltonian_cycle_search_checker.sv
test/hamiltonian_cycle_search_test.sv
